>>> sv/asc_pkg.sv
// Shared types, codes and constants of the alarm sensor command slave.
package asc_pkg;

    // Key storage size and the width of its byte index
    localparam int KEY_BYTES = 8;
    localparam int KEY_IDX_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIP_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNATURE_BYTE = 2'd1;

    // Register reset values
    localparam logic [9:0] TRIP_THRESHOLD_RST = 10'd450;
    localparam logic [7:0] SIGNATURE_BYTE_RST = 8'b1100_1011;
    localparam logic [6:0] SLAVE_ADDR_RST     = 7'd127;

    // Item kinds carried in tuser
    localparam logic [1:0] OP_COMMAND = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_SAMPLE  = 2'd2;

    // Command bytes
    localparam logic [7:0] CMD_SET_ADDR    = 8'd128;
    localparam logic [7:0] CMD_LOAD_KEY    = 8'd127;
    localparam logic [7:0] CMD_READ_ALARM  = 8'd125;
    localparam logic [7:0] CMD_READ_KEY    = 8'd124;
    localparam logic [7:0] CMD_LOAD_KEY_B  = 8'd123;
    localparam logic [7:0] CMD_ALARM_ON    = 8'd122;
    localparam logic [7:0] CMD_ALARM_OFF   = 8'd121;

    // Byte returned by an acknowledge read
    localparam logic [7:0] ACK_BYTE = 8'd200;

    // Armed read, one-hot
    typedef enum logic [4:0] {
        MODE_IDLE  = 5'b00001,
        MODE_ACK   = 5'b00010,
        MODE_SIG   = 5'b00100,
        MODE_ALARM = 5'b01000,
        MODE_KEY   = 5'b10000
    } t_read_mode;

    // One input word
    typedef struct packed {
        logic [9:0]  sensor_sample;
        logic [63:0] payload;
        logic [7:0]  command_code;
        logic [1:0]  opcode;
    } t_item;

    // One result word
    typedef struct packed {
        logic       alarm_active;
        logic [6:0] bus_address;
        logic [7:0] read_data;
        logic       read_valid;
    } t_result;

endpackage

>>> sv/asc_in_reg.sv
// Input register of the alarm sensor command slave: holds one accepted word.
module asc_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  asc_pkg::t_item i_item,
    input  logic          i_advance,
    output logic          o_valid,
    output asc_pkg::t_item o_item
);

    logic           r_valid;
    asc_pkg::t_item r_item;

    // Take a new word when empty or when the held one moves on
    assign o_ready = !r_valid || i_advance;

    // Hold valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Capture payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

>>> sv/asc_exec.sv
// Decode and state update of the alarm sensor command slave.
module asc_exec (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [asc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [asc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_fire,
    input  asc_pkg::t_item                  i_item,
    output asc_pkg::t_result                o_result
);

    logic [9:0]                     r_thresh;
    logic [7:0]                     r_sig;
    asc_pkg::t_read_mode            r_mode, n_mode;
    logic [7:0]                     r_key [asc_pkg::KEY_BYTES];
    logic [7:0]                     n_key [asc_pkg::KEY_BYTES];
    logic [asc_pkg::KEY_IDX_W-1:0]  r_key_idx, n_key_idx;
    logic                           r_alarm, n_alarm;
    logic [6:0]                     r_addr, n_addr;
    logic                           rd_valid;
    logic [7:0]                     rd_data;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= asc_pkg::TRIP_THRESHOLD_RST;
            r_sig    <= asc_pkg::SIGNATURE_BYTE_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == asc_pkg::CFG_TRIP_THRESHOLD) begin
                r_thresh <= i_cfg_data[9:0];
            end else if (i_cfg_index == asc_pkg::CFG_SIGNATURE_BYTE) begin
                r_sig <= i_cfg_data[7:0];
            end
        end
    end

    // Next state and read byte for the word in the input register
    always_comb begin
        n_mode    = r_mode;
        n_key     = r_key;
        n_key_idx = r_key_idx;
        n_alarm   = r_alarm;
        n_addr    = r_addr;
        rd_valid  = 1'b0;
        rd_data   = '0;
        unique case (i_item.opcode)
            asc_pkg::OP_COMMAND: begin
                unique case (i_item.command_code)
                    asc_pkg::CMD_SET_ADDR: begin
                        n_mode = asc_pkg::MODE_SIG;
                        n_addr = i_item.payload[6:0];
                    end
                    asc_pkg::CMD_LOAD_KEY, asc_pkg::CMD_LOAD_KEY_B: begin
                        n_mode = asc_pkg::MODE_ACK;
                        for (int i = 0; i < asc_pkg::KEY_BYTES; i++) begin
                            n_key[i] = i_item.payload[8*i +: 8];
                        end
                    end
                    asc_pkg::CMD_READ_ALARM: begin
                        n_mode = asc_pkg::MODE_ALARM;
                    end
                    asc_pkg::CMD_READ_KEY: begin
                        n_mode = asc_pkg::MODE_KEY;
                    end
                    asc_pkg::CMD_ALARM_ON: begin
                        n_mode  = asc_pkg::MODE_ACK;
                        n_alarm = 1'b1;
                    end
                    asc_pkg::CMD_ALARM_OFF: begin
                        n_mode  = asc_pkg::MODE_ACK;
                        n_alarm = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            asc_pkg::OP_READ: begin
                unique case (r_mode)
                    asc_pkg::MODE_ACK: begin
                        rd_valid = 1'b1;
                        rd_data  = asc_pkg::ACK_BYTE;
                        n_mode   = asc_pkg::MODE_IDLE;
                    end
                    asc_pkg::MODE_SIG: begin
                        rd_valid = 1'b1;
                        rd_data  = r_sig;
                        n_mode   = asc_pkg::MODE_IDLE;
                    end
                    asc_pkg::MODE_ALARM: begin
                        rd_valid = 1'b1;
                        rd_data  = {7'd0, r_alarm};
                        n_mode   = asc_pkg::MODE_IDLE;
                    end
                    asc_pkg::MODE_KEY: begin
                        rd_valid = 1'b1;
                        rd_data  = r_key[r_key_idx];
                        // Disarm after the last key byte
                        if (r_key_idx == asc_pkg::KEY_IDX_W'(asc_pkg::KEY_BYTES - 1)) begin
                            n_key_idx = '0;
                            n_mode    = asc_pkg::MODE_IDLE;
                        end else begin
                            n_key_idx = r_key_idx + asc_pkg::KEY_IDX_W'(1);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            asc_pkg::OP_SAMPLE: begin
                n_alarm = (i_item.sensor_sample < r_thresh);
            end
            default: begin
            end
        endcase
    end

    // Advance state when the word moves to the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= asc_pkg::MODE_ACK;
            r_key_idx <= '0;
            r_alarm   <= 1'b0;
            r_addr    <= asc_pkg::SLAVE_ADDR_RST;
            for (int i = 0; i < asc_pkg::KEY_BYTES; i++) begin
                r_key[i] <= '0;
            end
        end else if (i_fire) begin
            r_mode    <= n_mode;
            r_key_idx <= n_key_idx;
            r_alarm   <= n_alarm;
            r_addr    <= n_addr;
            r_key     <= n_key;
        end
    end

    assign o_result.read_valid   = rd_valid;
    assign o_result.read_data    = rd_data;
    assign o_result.bus_address  = n_addr;
    assign o_result.alarm_active = n_alarm;

endmodule

>>> sv/asc_out_reg.sv
// Output register of the alarm sensor command slave: holds one result word.
module asc_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  asc_pkg::t_result i_result,
    output logic             o_free,
    output logic             o_valid,
    input  logic             i_ready,
    output asc_pkg::t_result o_result
);

    logic             r_valid;
    asc_pkg::t_result r_result;

    // Free when empty or when the held word leaves this cycle
    assign o_free = !r_valid || i_ready;

    // Hold valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    // Capture result
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

>>> sv/alarm_sensor_command_slave_core.sv
// Top level of the alarm sensor command slave: stream in, stream out, config writes.
//
//  channel   direction  handshake                      content
//  s_axis    in         i_s_axis_tvalid/o_s_axis_tready command, read request or sample
//  m_axis    out        o_m_axis_tvalid/i_m_axis_tready read byte, address, alarm
//  cfg       in         i_cfg_valid/o_cfg_ready         register index and data
//
//  Every word gives one result word: the input register holds the accepted word while
//  decode and state update feed the output register. A new word is taken every cycle
//  while the output register has room; it frees its slot in the same cycle the
//  downstream takes its word, so a stall holds both registers.
//  Reset (i_rst_n low, synchronous) empties both registers and restores state.
//  Config writes are taken every cycle (o_cfg_ready is always high).
module alarm_sensor_command_slave_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // tdata: command_code[7:0], payload[71:8], sensor_sample[81:72], zero pad[87:82]
    input  logic [87:0]                     i_s_axis_tdata,
    // tuser: opcode[1:0]
    input  logic [1:0]                      i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // tdata: read_data[7:0], bus_address[14:8], alarm_active[15]
    output logic [15:0]                     o_m_axis_tdata,
    // tuser: read_valid[0]
    output logic                            o_m_axis_tuser,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [asc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [asc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    asc_pkg::t_item   in_item;
    asc_pkg::t_item   held_item;
    asc_pkg::t_result exec_result;
    asc_pkg::t_result out_result;
    logic             held_valid;
    logic             out_free;
    logic             fire;

    // Unpack the input word
    assign in_item.opcode        = i_s_axis_tuser;
    assign in_item.command_code  = i_s_axis_tdata[7:0];
    assign in_item.payload       = i_s_axis_tdata[71:8];
    assign in_item.sensor_sample = i_s_axis_tdata[81:72];

    // Move a word forward when the output register has room
    assign fire        = held_valid && out_free;
    assign o_cfg_ready = 1'b1;

    asc_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_item    (in_item),
        .i_advance (fire),
        .o_valid   (held_valid),
        .o_item    (held_item)
    );

    asc_exec u_exec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (fire),
        .i_item      (held_item),
        .o_result    (exec_result)
    );

    asc_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire),
        .i_result (exec_result),
        .o_free   (out_free),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (out_result)
    );

    // Pack the result word
    assign o_m_axis_tdata = {out_result.alarm_active, out_result.bus_address,
                             out_result.read_data};
    assign o_m_axis_tuser = out_result.read_valid;

endmodule

>>> tb/tb_alarm_sensor_command_slave_core.sv
// Self-checking testbench for the alarm sensor command slave: directed and random words.
module tb_alarm_sensor_command_slave_core;
    timeunit 1ns;
    timeprecision 1ps;

    import asc_pkg::*;

    // Codes the block ignores
    localparam logic [1:0]           OP_SPARE    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam int PHASES          = 5;
    localparam int WORDS_PER_PHASE = 385;

    // Predicts the reply word of every accepted word and checks replies in order
    class reply_predictor;
        logic [9:0]           threshold;
        logic [7:0]           signature;
        t_read_mode           mode;
        logic [7:0]           key_mem [KEY_BYTES];
        logic [KEY_IDX_W-1:0] key_pos;
        logic                 alarm;
        logic [6:0]           addr;
        t_result              replies_due [$];
        int                   mismatches;
        int                   words_in;
        int                   bytes_read;
        int                   key_bytes_read;
        int                   checked;

        function new();
            threshold = TRIP_THRESHOLD_RST;
            signature = SIGNATURE_BYTE_RST;
            mode      = MODE_ACK;
            foreach (key_mem[i]) key_mem[i] = 8'd0;
            key_pos        = '0;
            alarm          = 1'b0;
            addr           = SLAVE_ADDR_RST;
            mismatches     = 0;
            words_in       = 0;
            bytes_read     = 0;
            key_bytes_read = 0;
            checked        = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_TRIP_THRESHOLD: threshold = data;
                CFG_SIGNATURE_BYTE: signature = data[7:0];
                default: ;
            endcase
        endfunction

        function void take_word(t_item w);
            t_result r;
            r = '0;
            words_in++;
            case (w.opcode)
                OP_COMMAND: begin
                    case (w.command_code)
                        CMD_SET_ADDR: begin
                            mode = MODE_SIG;
                            addr = w.payload[6:0];
                        end
                        CMD_LOAD_KEY, CMD_LOAD_KEY_B: begin
                            mode = MODE_ACK;
                            foreach (key_mem[i]) key_mem[i] = w.payload[8*i +: 8];
                        end
                        CMD_READ_ALARM: mode = MODE_ALARM;
                        CMD_READ_KEY:   mode = MODE_KEY;
                        CMD_ALARM_ON: begin
                            mode  = MODE_ACK;
                            alarm = 1'b1;
                        end
                        CMD_ALARM_OFF: begin
                            mode  = MODE_ACK;
                            alarm = 1'b0;
                        end
                        default: ;
                    endcase
                end
                OP_READ: begin
                    r.read_valid = (mode != MODE_IDLE);
                    case (mode)
                        MODE_ACK:   r.read_data = ACK_BYTE;
                        MODE_SIG:   r.read_data = signature;
                        MODE_ALARM: r.read_data = {7'd0, alarm};
                        MODE_KEY: begin
                            r.read_data = key_mem[key_pos];
                            key_bytes_read++;
                        end
                        default: ;
                    endcase
                    // key readout walks the store and disarms after its last byte
                    if (mode == MODE_KEY && int'(key_pos) != KEY_BYTES - 1) begin
                        key_pos++;
                    end else begin
                        if (mode == MODE_KEY) key_pos = '0;
                        mode = MODE_IDLE;
                    end
                    if (r.read_valid) bytes_read++;
                end
                OP_SAMPLE: alarm = (w.sensor_sample < threshold);
                default: ;
            endcase
            r.bus_address  = addr;
            r.alarm_active = alarm;
            replies_due.push_back(r);
        endfunction

        task report(string what, int got, int want);
            mismatches++;
            $display("MISMATCH reply %0d %s: got %0d, want %0d", checked, what, got, want);
        endtask

        task check_reply(t_result got);
            t_result want;
            checked++;
            if (replies_due.size() == 0) begin
                report("reply with none due", 1, 0);
                return;
            end
            want = replies_due.pop_front();
            if (got.read_valid !== want.read_valid)
                report("read_valid", got.read_valid, want.read_valid);
            if (got.read_data !== want.read_data)
                report("read_data", got.read_data, want.read_data);
            if (got.bus_address !== want.bus_address)
                report("bus_address", got.bus_address, want.bus_address);
            if (got.alarm_active !== want.alarm_active)
                report("alarm_active", got.alarm_active, want.alarm_active);
        endtask
    endclass

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic [87:0]           i_s_axis_tdata  = '0;
    logic [1:0]            i_s_axis_tuser  = '0;
    logic                  i_m_axis_tready = 1'b0;
    logic                  i_cfg_valid     = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [15:0]           o_m_axis_tdata;
    logic                  o_m_axis_tuser;
    logic                  o_cfg_ready;

    reply_predictor board = new();
    int             burst_left = 0;
    int             settings_used = 1;
    logic [11:0]    stall_clock = '0;

    alarm_sensor_command_slave_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: rotate through always-ready, light, periodic and heavy stalls
    always @(posedge i_clk) begin
        stall_clock <= stall_clock + 12'd1;
        case (stall_clock[9:8])
            2'd0: i_m_axis_tready <= 1'b1;
            2'd1: i_m_axis_tready <= ($urandom_range(0, 2) != 0);
            2'd2: i_m_axis_tready <= (stall_clock[1:0] != 2'd0);
            default: i_m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Check every reply word taken by the receiver
    always @(posedge i_clk) begin
        t_result got;
        got = {o_m_axis_tdata, o_m_axis_tuser};
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) board.check_reply(got);
    end

    function automatic t_item mk(logic [1:0] op, logic [7:0] code, logic [63:0] pl,
                                 logic [9:0] smp);
        return {smp, pl, code, op};
    endfunction

    function automatic logic [63:0] rand_payload();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [9:0] rand_sample();
        return 10'($urandom_range(0, 1023));
    endfunction

    function automatic logic [7:0] known_code();
        case ($urandom_range(0, 6))
            0: return CMD_SET_ADDR;
            1: return CMD_LOAD_KEY;
            2: return CMD_READ_ALARM;
            3: return CMD_READ_KEY;
            4: return CMD_LOAD_KEY_B;
            5: return CMD_ALARM_ON;
            default: return CMD_ALARM_OFF;
        endcase
    endfunction

    function automatic logic [7:0] unknown_code();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (c == CMD_SET_ADDR || c == CMD_LOAD_KEY || c == CMD_READ_ALARM ||
                   c == CMD_READ_KEY || c == CMD_LOAD_KEY_B || c == CMD_ALARM_ON ||
                   c == CMD_ALARM_OFF);
        return c;
    endfunction

    // Four in ten samples land on or beside the trip point
    function automatic logic [9:0] pick_sample();
        int v;
        case ($urandom_range(0, 9))
            0: return 10'd0;
            1: return 10'd1023;
            2, 3, 4, 5: begin
                v = int'(board.threshold) + int'($urandom_range(0, 2)) - 1;
                if (v < 0) v = 0;
                if (v > 1023) v = 1023;
                return 10'(v);
            end
            default: return rand_sample();
        endcase
    endfunction

    // Drive one word, hold it until taken, then keep or break the burst
    task automatic send_word(input t_item w);
        int gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {6'd0, w.sensor_sample, w.payload, w.command_code};
        i_s_axis_tuser  <= w.opcode;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        board.take_word(w);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic read_word();
        send_word(mk(OP_READ, 8'($urandom), rand_payload(), rand_sample()));
    endtask

    // Stop sending and wait for every reply due
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (board.replies_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.write_reg(idx, data);
    endtask

    task automatic close_writes();
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        settings_used++;
    endtask

    task automatic run_directed();
        // the acknowledge armed by reset, then a read with nothing armed
        read_word();
        read_word();
        // samples around the trip point and at the ends of the range
        send_word(mk(OP_SAMPLE, 8'd0, 64'd0, TRIP_THRESHOLD_RST - 10'd1));
        send_word(mk(OP_SAMPLE, 8'hFF, '1, TRIP_THRESHOLD_RST));
        send_word(mk(OP_SAMPLE, 8'd0, 64'd0, 10'd0));
        send_word(mk(OP_SAMPLE, 8'hFF, '1, 10'd1023));
        // alarm status both ways, forced on and off
        send_word(mk(OP_COMMAND, CMD_READ_ALARM, 64'd0, 10'd0));
        read_word();
        send_word(mk(OP_COMMAND, CMD_ALARM_ON, 64'd0, 10'd0));
        read_word();
        send_word(mk(OP_COMMAND, CMD_READ_ALARM, '1, 10'd1023));
        read_word();
        send_word(mk(OP_COMMAND, CMD_ALARM_OFF, '1, 10'd1023));
        // address change: masked to 7 bits, then the signature read
        send_word(mk(OP_COMMAND, CMD_SET_ADDR, '1, 10'd0));
        read_word();
        send_word(mk(OP_COMMAND, CMD_SET_ADDR, 64'hFFFF_FFFF_FFFF_FF80, 10'd0));
        read_word();
        // interrupted key readout resumes where it stopped after a reload
        send_word(mk(OP_COMMAND, CMD_LOAD_KEY, 64'h0123_4567_89AB_CDEF, 10'd0));
        send_word(mk(OP_COMMAND, CMD_READ_KEY, 64'd0, 10'd0));
        repeat (3) read_word();
        send_word(mk(OP_COMMAND, CMD_LOAD_KEY_B, 64'hFEDC_BA98_7654_3210, 10'd0));
        send_word(mk(OP_COMMAND, CMD_READ_KEY, 64'd0, 10'd0));
        // unknown commands and the unused kind leave the readout armed
        send_word(mk(OP_COMMAND, 8'd0, '1, 10'd1023));
        send_word(mk(OP_COMMAND, 8'hFF, '1, 10'd1023));
        send_word(mk(OP_SPARE, 8'hFF, '1, 10'd1023));
        read_word();
    endtask

    // Mostly well-formed command and read sequences, with some noise
    task automatic run_random(input int n);
        int    sent;
        int    roll;
        sent = 0;
        while (sent < n) begin
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
                send_word(mk(OP_COMMAND, known_code(), rand_payload(), rand_sample()));
                sent++;
                repeat (($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3)) begin
                    read_word();
                    sent++;
                end
            end else if (roll < 60) begin
                if ($urandom_range(0, 1) == 0) begin
                    send_word(mk(OP_COMMAND, CMD_LOAD_KEY, rand_payload(), rand_sample()));
                    sent++;
                end
                send_word(mk(OP_COMMAND, CMD_READ_KEY, rand_payload(), rand_sample()));
                sent++;
                repeat ($urandom_range(1, 10)) begin
                    read_word();
                    sent++;
                end
            end else if (roll < 82) begin
                repeat ($urandom_range(1, 4)) begin
                    send_word(mk(OP_SAMPLE, 8'($urandom), rand_payload(), pick_sample()));
                    sent++;
                end
            end else if (roll < 90) begin
                read_word();
                sent++;
            end else if (roll < 95) begin
                send_word(mk(OP_COMMAND, unknown_code(), rand_payload(), rand_sample()));
                sent++;
            end else begin
                send_word(mk(OP_SPARE, 8'($urandom), rand_payload(), rand_sample()));
                sent++;
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        run_random(WORDS_PER_PHASE);

        for (int p = 1; p < PHASES; p++) begin
            drain();
            case (p)
                1: begin
                    write_reg(CFG_TRIP_THRESHOLD, 10'd0);
                    write_reg(CFG_SIGNATURE_BYTE, 10'd0);
                    write_reg(CFG_SPARE_A, '1);
                    write_reg(CFG_SPARE_B, 10'h155);
                end
                2: begin
                    write_reg(CFG_TRIP_THRESHOLD, 10'd1023);
                    write_reg(CFG_SIGNATURE_BYTE, '1);
                end
                3: begin
                    write_reg(CFG_TRIP_THRESHOLD, 10'($urandom_range(0, 1023)));
                    write_reg(CFG_SIGNATURE_BYTE, 10'($urandom_range(0, 1023)));
                    write_reg(CFG_SPARE_A, 10'($urandom_range(0, 1023)));
                end
                default: begin
                    write_reg(CFG_TRIP_THRESHOLD, 10'd1);
                    write_reg(CFG_SIGNATURE_BYTE, 10'($urandom_range(0, 1023)));
                end
            endcase
            close_writes();
            run_random(WORDS_PER_PHASE);
        end

        drain();
        $display("Sent %0d words under %0d register settings; %0d replies checked.",
                 board.words_in, settings_used, board.checked);
        $display("Reads returned %0d bytes, %0d from key readouts; %0d mismatches.",
                 board.bytes_read, board.key_bytes_read, board.mismatches);
        if (board.mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog: a hang anywhere ends the run as a failure
    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
